// File: src/assert_macros.svh
// Assertion helpers shared by the packer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define FFBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check a property on every rising edge, reset included.
`define FFBP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) \
      else $error(msg);

`endif

// File: src/ffbp_pkg.sv
package ffbp_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ITEMS_DEF   = 256;
   localparam int WEIGHT_BITS_DEF = 16;

   // Fixed port widths and the bins-used saturation value
   localparam int REQ_WEIGHT_W = 16;
   localparam int BINS_USED_W  = 9;
   localparam int BINS_SAT     = 511;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_CAPACITY    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SORT_DECREASING = 1'b1;

   localparam logic [CSR_DATA_W-1:0] CAP_RESET = 16'd100;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic store;        // write the incoming weight or mark a drop
      logic sort_i_init;  // i = 1
      logic pack_i_init;  // i = 0
      logic i_inc;
      logic rd_item_i;    // read item store at i
      logic rd_item_jm1;  // read item store at j - 1
      logic v_load;       // v = item read data
      logic j_init;       // j = i
      logic j_dec;
      logic wr_item_d;    // item[j] = item read data
      logic wr_item_v;    // item[j] = v
      logic room_init;    // room[0] = capacity, bins = 1
      logic rd_room_b;    // read bin room at b
      logic b_clear;
      logic b_inc;
      logic room_sub;     // room[b] -= v
      logic room_open;    // room[bins] = capacity - v, bins++
      logic result_load;  // capture result, clear the set
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic multi;   // more than one item stored
      logic i_last;  // i + 1 == count
      logic j_one;   // j == 1
      logic less;    // item read data < v
      logic fits;    // v <= room read data
      logic b_last;  // b + 1 == bins
   } status_type;

endpackage

// File: src/first_fit_bin_packer.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_item_weight, req_last_item
// rsp_      out        rsp_valid/rsp_stall  rsp_bins_used, rsp_overflow
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// One item loads per cycle while req_stall is low. The last item leads to a
// start state, an insertion sort into decreasing order when sort_decreasing
// is set and more than one item is stored, first-fit packing and a finish
// state that waits for a free output; req_stall stays high throughout.
// Reset is synchronous and clears control state only: no clearing pass.
// A waiting result holds in the output register while the next set loads.
module first_fit_bin_packer #(
   parameter int MAX_ITEMS   = ffbp_pkg::MAX_ITEMS_DEF,
   parameter int WEIGHT_BITS = ffbp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ffbp_pkg::REQ_WEIGHT_W-1:0]  req_item_weight,
   input  logic                               req_last_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ffbp_pkg::BINS_USED_W-1:0]   rsp_bins_used,
   output logic                               rsp_overflow,
   input  logic                               csr_write_enable,
   input  logic [ffbp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ffbp_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic [ffbp_pkg::CSR_DATA_W-1:0] bin_capacity_ff;
   logic                            sort_decreasing_ff;
   ffbp_pkg::cmd_type               cmd;
   ffbp_pkg::status_type            status;

   // Configuration registers: take a write on any enabled edge
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_capacity_ff    <= ffbp_pkg::CAP_RESET;
         sort_decreasing_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ffbp_pkg::CSR_BIN_CAPACITY:    bin_capacity_ff    <= csr_write_data;
            ffbp_pkg::CSR_SORT_DECREASING: sort_decreasing_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Sequence loading, sorting, packing and result hand-off
   ffbp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_item   (req_last_item),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .sort_decreasing (sort_decreasing_ff),
      .status          (status),
      .cmd             (cmd)
   );

   // Hold the item store, bin rooms, counters and the result register
   ffbp_dpath #(
      .MAX_ITEMS   (MAX_ITEMS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_item_weight (req_item_weight),
      .bin_capacity    (bin_capacity_ff),
      .rsp_bins_used   (rsp_bins_used),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

// File: src/ffbp_ctrl.sv
`include "assert_macros.svh"

module ffbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_item,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 sort_decreasing,
   input  ffbp_pkg::status_type status,
   output ffbp_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_LOAD      = 4'd0;
   localparam logic [3:0] ST_START     = 4'd1;
   localparam logic [3:0] ST_SORT_RD   = 4'd2;
   localparam logic [3:0] ST_SORT_V    = 4'd3;
   localparam logic [3:0] ST_SORT_CRD  = 4'd4;
   localparam logic [3:0] ST_SORT_CMP  = 4'd5;
   localparam logic [3:0] ST_SORT_PUT  = 4'd6;
   localparam logic [3:0] ST_PACK_INIT = 4'd7;
   localparam logic [3:0] ST_PACK_RD   = 4'd8;
   localparam logic [3:0] ST_PACK_W    = 4'd9;
   localparam logic [3:0] ST_BIN_RD    = 4'd10;
   localparam logic [3:0] ST_BIN_CMP   = 4'd11;
   localparam logic [3:0] ST_OPEN      = 4'd12;
   localparam logic [3:0] ST_NEXT      = 4'd13;
   localparam logic [3:0] ST_FINISH    = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last_item) state_in = ST_START;
            end
         end
         ST_START: begin
            if (sort_decreasing && status.multi) begin
               cmd.sort_i_init = 1'b1;
               state_in        = ST_SORT_RD;
            end else begin
               state_in = ST_PACK_INIT;
            end
         end
         ST_SORT_RD: begin
            cmd.rd_item_i = 1'b1;
            state_in      = ST_SORT_V;
         end
         ST_SORT_V: begin
            cmd.v_load = 1'b1;
            cmd.j_init = 1'b1;
            state_in   = ST_SORT_CRD;
         end
         ST_SORT_CRD: begin
            cmd.rd_item_jm1 = 1'b1;
            state_in        = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            if (status.less) begin
               cmd.wr_item_d = 1'b1;
               cmd.j_dec     = 1'b1;
               state_in      = status.j_one ? ST_SORT_PUT : ST_SORT_CRD;
            end else begin
               state_in = ST_SORT_PUT;
            end
         end
         ST_SORT_PUT: begin
            cmd.wr_item_v = 1'b1;
            cmd.i_inc     = 1'b1;
            state_in      = status.i_last ? ST_PACK_INIT : ST_SORT_RD;
         end
         ST_PACK_INIT: begin
            cmd.room_init   = 1'b1;
            cmd.pack_i_init = 1'b1;
            state_in        = ST_PACK_RD;
         end
         ST_PACK_RD: begin
            cmd.rd_item_i = 1'b1;
            state_in      = ST_PACK_W;
         end
         ST_PACK_W: begin
            cmd.v_load  = 1'b1;
            cmd.b_clear = 1'b1;
            state_in    = ST_BIN_RD;
         end
         ST_BIN_RD: begin
            cmd.rd_room_b = 1'b1;
            state_in      = ST_BIN_CMP;
         end
         ST_BIN_CMP: begin
            if (status.fits) begin
               cmd.room_sub = 1'b1;
               state_in     = ST_NEXT;
            end else if (status.b_last) begin
               state_in = ST_OPEN;
            end else begin
               cmd.b_inc = 1'b1;
               state_in  = ST_BIN_RD;
            end
         end
         ST_OPEN: begin
            cmd.room_open = 1'b1;
            state_in      = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.i_inc = 1'b1;
            state_in  = status.i_last ? ST_FINISH : ST_PACK_RD;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FFBP_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH, "result appeared outside finish")
   `FFBP_ASSERT(a_finish_waits, clock, reset, (state_ff == ST_FINISH) && rsp_valid_ff && rsp_stall |=> state_ff == ST_FINISH, "finish overran a waiting result")
   `FFBP_ASSERT(a_store_only_loading, clock, reset, cmd.store |-> !req_stall && req_valid, "store outside an accepted transaction")

endmodule

// File: src/ffbp_dpath.sv
`include "assert_macros.svh"

module ffbp_dpath #(
   parameter int MAX_ITEMS   = ffbp_pkg::MAX_ITEMS_DEF,
   parameter int WEIGHT_BITS = ffbp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ffbp_pkg::cmd_type                   cmd,
   output ffbp_pkg::status_type                status,
   input  logic [ffbp_pkg::REQ_WEIGHT_W-1:0]   req_item_weight,
   input  logic [ffbp_pkg::CSR_DATA_W-1:0]     bin_capacity,
   output logic [ffbp_pkg::BINS_USED_W-1:0]    rsp_bins_used,
   output logic                                rsp_overflow
);

   localparam int IW  = $clog2(MAX_ITEMS);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int RIW = $clog2(MAX_ITEMS + 1);
   localparam int BW  = $clog2(MAX_ITEMS + 2);
   localparam int RW  = ((WEIGHT_BITS > ffbp_pkg::CSR_DATA_W) ?
                         WEIGHT_BITS : ffbp_pkg::CSR_DATA_W) + 1;

   logic [WEIGHT_BITS-1:0] item_mem [MAX_ITEMS];
   logic signed [RW-1:0]   room_mem [MAX_ITEMS + 1];

   logic [WEIGHT_BITS-1:0] item_rd_ff, v_ff;
   logic signed [RW-1:0]   room_rd_ff;
   logic [CW-1:0]          count_ff, i_ff, j_ff, jm1;
   logic [BW-1:0]          b_ff, bins_ff;
   logic                   dropped_ff;
   logic [ffbp_pkg::BINS_USED_W-1:0] bins_out_ff;
   logic                   overflow_ff;

   logic [31:0]            w_wide, bins_wide;
   logic [WEIGHT_BITS-1:0] w_store;
   logic                   room_left;
   logic                   item_we, room_we;
   logic [IW-1:0]          item_wa, item_ra;
   logic [WEIGHT_BITS-1:0] item_wd;
   logic [RIW-1:0]         room_wa;
   logic signed [RW-1:0]   room_wd, v_s, cap_s;
   logic [ffbp_pkg::BINS_USED_W-1:0] bins_sat;

   assign w_wide    = 32'(req_item_weight);
   assign w_store   = w_wide[WEIGHT_BITS-1:0];
   assign room_left = (count_ff < CW'(MAX_ITEMS));
   assign jm1       = j_ff - CW'(1);
   assign v_s       = signed'(RW'(v_ff));
   assign cap_s     = signed'(RW'(bin_capacity));

   assign status.multi  = (count_ff > CW'(1));
   assign status.i_last = ((i_ff + CW'(1)) == count_ff);
   assign status.j_one  = (j_ff == CW'(1));
   assign status.less   = (item_rd_ff < v_ff);
   assign status.fits   = (v_s <= room_rd_ff);
   assign status.b_last = ((b_ff + BW'(1)) == bins_ff);

   // Item store port selection
   always_comb begin
      item_we = (cmd.store && room_left) || cmd.wr_item_d || cmd.wr_item_v;
      item_wa = cmd.store ? count_ff[IW-1:0] : j_ff[IW-1:0];
      if (cmd.store)          item_wd = w_store;
      else if (cmd.wr_item_d) item_wd = item_rd_ff;
      else                    item_wd = v_ff;
      item_ra = cmd.rd_item_jm1 ? jm1[IW-1:0] : i_ff[IW-1:0];
   end

   // Bin room port selection
   always_comb begin
      room_we = cmd.room_init || cmd.room_sub ||
                (cmd.room_open && (bins_ff < BW'(MAX_ITEMS + 1)));
      if (cmd.room_init) begin
         room_wa = '0;
         room_wd = cap_s;
      end else if (cmd.room_sub) begin
         room_wa = b_ff[RIW-1:0];
         room_wd = room_rd_ff - v_s;
      end else begin
         room_wa = bins_ff[RIW-1:0];
         room_wd = cap_s - v_s;
      end
   end

   always_ff @(posedge clock) begin
      if (item_we) item_mem[item_wa] <= item_wd;
      if (cmd.rd_item_i || cmd.rd_item_jm1) item_rd_ff <= item_mem[item_ra];
   end

   always_ff @(posedge clock) begin
      if (room_we) room_mem[room_wa] <= room_wd;
      if (cmd.rd_room_b) room_rd_ff <= room_mem[b_ff[RIW-1:0]];
   end

   assign bins_wide = 32'(bins_ff);
   assign bins_sat  = (bins_wide > 32'(ffbp_pkg::BINS_SAT)) ?
                      ffbp_pkg::BINS_USED_W'(ffbp_pkg::BINS_SAT) :
                      bins_wide[ffbp_pkg::BINS_USED_W-1:0];

   // Set bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         bins_ff    <= '0;
      end else begin
         if (cmd.store) begin
            if (room_left) count_ff <= count_ff + CW'(1);
            else           dropped_ff <= 1'b1;
         end
         if (cmd.result_load) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end
         if (cmd.room_init) bins_ff <= BW'(1);
         else if (cmd.room_open && (bins_ff < BW'(MAX_ITEMS + 1)))
            bins_ff <= bins_ff + BW'(1);
      end
   end

   // Loop indexes, held weight and the result register
   always_ff @(posedge clock) begin
      if (cmd.sort_i_init)      i_ff <= CW'(1);
      else if (cmd.pack_i_init) i_ff <= '0;
      else if (cmd.i_inc)       i_ff <= i_ff + CW'(1);
      if (cmd.j_init)     j_ff <= i_ff;
      else if (cmd.j_dec) j_ff <= jm1;
      if (cmd.b_clear)    b_ff <= '0;
      else if (cmd.b_inc) b_ff <= b_ff + BW'(1);
      if (cmd.v_load) v_ff <= item_rd_ff;
      if (cmd.result_load) begin
         bins_out_ff <= bins_sat;
         overflow_ff <= dropped_ff;
      end
   end

   assign rsp_bins_used = bins_out_ff;
   assign rsp_overflow  = overflow_ff;

   `FFBP_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CW'(MAX_ITEMS)), "item count past store depth")
   `FFBP_ASSERT(a_set_cleared, clock, reset, cmd.result_load |=> (count_ff == '0) && !dropped_ff, "set not cleared after result")
   `FFBP_ASSERT(a_bins_bound, clock, reset, bins_ff <= BW'(MAX_ITEMS + 1), "bin count past room depth")

endmodule
